// File: design/ckwlf_pkg.sv
// ----------------------------------------------------------------------------
// ckwlf_pkg
// Shared constants and types for the caseless keyword line filter: the
// keyword list, stored last byte first, and the keyword lengths.
// ----------------------------------------------------------------------------
package ckwlf_pkg;

  localparam int KEY_COUNT = 18;
  localparam int KEY_MAX   = 7;
  localparam int WIN_DEPTH = KEY_MAX - 1;
  localparam int KEY_IDX_W = $clog2(KEY_COUNT);
  localparam int KEY_LEN_W = $clog2(KEY_MAX + 1);

  localparam logic [7:0] FOLD_LO     = 8'h41;  // 'A'
  localparam logic [7:0] FOLD_HI     = 8'h5A;  // 'Z'
  localparam logic [7:0] FOLD_OFFSET = 8'h20;

  // byte j of an entry is the keyword's byte j places before its last one
  typedef logic [KEY_MAX-1:0][7:0] key_text_t;
  typedef logic [KEY_LEN_W-1:0]    key_len_t;
  typedef logic [KEY_IDX_W-1:0]    key_idx_t;
  typedef logic [KEY_COUNT-1:0]    key_hits_t;

  localparam key_text_t KEY_TEXT [KEY_COUNT] = '{
    key_text_t'("audio"),
    key_text_t'("snd"),
    key_text_t'("audsrv"),
    key_text_t'("libsd"),
    key_text_t'("iwad"),
    key_text_t'("build"),
    key_text_t'("game:"),
    key_text_t'("error"),
    key_text_t'(">>>"),
    key_text_t'("==="),
    key_text_t'("opl"),
    key_text_t'("music"),
    key_text_t'("adlib"),
    key_text_t'("genmidi"),
    key_text_t'("midi"),
    key_text_t'("dude"),
    key_text_t'("spu"),
    key_text_t'("menu")
  };

  localparam key_len_t KEY_LEN [KEY_COUNT] = '{
    key_len_t'(5), key_len_t'(3), key_len_t'(6), key_len_t'(5),
    key_len_t'(4), key_len_t'(5), key_len_t'(5), key_len_t'(5),
    key_len_t'(3), key_len_t'(3), key_len_t'(3), key_len_t'(5),
    key_len_t'(5), key_len_t'(7), key_len_t'(4), key_len_t'(4),
    key_len_t'(3), key_len_t'(4)
  };

endpackage

// File: design/caseless_keyword_line_filter.sv
// ----------------------------------------------------------------------------
// caseless_keyword_line_filter
// Case-insensitive search for eighteen fixed keywords in byte payloads, with
// one verdict beat per payload.
// ----------------------------------------------------------------------------
// Takes one payload byte per beat on the src channel, payload_end marking the
// last byte, and gives one beat on the res channel per payload: line_wanted is
// set if any keyword occurred (letters A..Z fold to lower case, other bytes
// compare as they are) and first_key_index names the first keyword in list
// order that occurred, 0 when none did. A byte is accepted every cycle while
// the result register is free or being drained; a payload end only waits when
// the previous verdict is still stalled on res. The last byte waits in the
// input register, then the window compare and hit update feed the result
// register that drives res. No match spans two payloads: window and hit
// bits clear on every payload end. No clearing pass after reset.
module caseless_keyword_line_filter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     src_valid,
  output logic                     src_stall,
  input  logic [7:0]               data_byte,
  input  logic                     payload_end,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic                     line_wanted,
  output ckwlf_pkg::key_idx_t      first_key_index
);
  import ckwlf_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;     // already folded
  logic       s1_end;

  // per-payload state
  logic [WIN_DEPTH-1:0][7:0] window;   // index 0 is the newest byte
  key_hits_t                 hits;

  logic                    src_accept;
  logic                    s1_adv;
  logic [7:0]              byte_folded;
  logic [KEY_MAX-1:0][7:0] view;
  key_hits_t               hits_now;
  key_hits_t               hits_next;
  logic                    wanted_next;
  key_idx_t                first_next;

  // stage 1 moves on unless it holds a payload end and the verdict
  // register is still full and stalled
  assign s1_adv     = !s1_end || !res_valid || !res_stall;
  assign src_stall  = s1_valid && !s1_adv;
  assign src_accept = src_valid && !src_stall;

  // case fold on the way in
  always_comb begin
    byte_folded = data_byte;
    if (data_byte inside {[FOLD_LO:FOLD_HI]}) begin
      byte_folded = data_byte + FOLD_OFFSET;
    end
  end

  // current byte followed by the history, oldest last
  always_comb begin
    view[0] = s1_byte;
    for (int j = 1; j < KEY_MAX; j++) begin
      view[j] = window[j-1];
    end
  end

  // parallel keyword compare: byte j of the view against the keyword byte
  // j places before its end, for j below the keyword length
  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      hits_now[k] = 1'b1;
      for (int j = 0; j < KEY_MAX; j++) begin
        if (KEY_LEN_W'(j) < KEY_LEN[k] && view[j] != KEY_TEXT[k][j]) begin
          hits_now[k] = 1'b0;
        end
      end
    end
  end

  assign hits_next = hits | hits_now;

  // lowest set hit wins
  always_comb begin
    wanted_next = |hits_next;
    first_next  = '0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (hits_next[k]) begin
        first_next = KEY_IDX_W'(k);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      window    <= '0;
      hits      <= '0;
    end else begin
      if (src_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && s1_adv && s1_end) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      // window and sticky hits follow each byte leaving stage 1
      if (s1_valid && s1_adv) begin
        if (s1_end) begin
          window <= '0;
          hits   <= '0;
        end else begin
          window <= {window[WIN_DEPTH-2:0], s1_byte};
          hits   <= hits_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (src_accept) begin
      s1_byte <= byte_folded;
      s1_end  <= payload_end;
    end
    if (s1_valid && s1_adv && s1_end) begin
      line_wanted     <= wanted_next;
      first_key_index <= first_next;
    end
  end

endmodule

// File: design/ckwlf_checker.sv
// ----------------------------------------------------------------------------
// ckwlf_checker
// Port-level checks for the caseless keyword line filter, bound to the top.
// ----------------------------------------------------------------------------
module ckwlf_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_stall,
  input logic                res_valid,
  input logic                res_stall,
  input logic                line_wanted,
  input ckwlf_pkg::key_idx_t first_key_index
);
  import ckwlf_pkg::*;

  // a stalled verdict holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(line_wanted)
      && $stable(first_key_index))
    else $error("verdict changed while stalled");

  // index stays inside the keyword list
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> first_key_index < KEY_IDX_W'(KEY_COUNT))
    else $error("keyword index out of range");

  // no match means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !line_wanted |-> first_key_index == '0)
    else $error("nonzero index without a match");

  // no verdict right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("verdict valid after reset");

  // source is never held while the verdict register is free
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !src_stall)
    else $error("source stalled with free verdict register");

endmodule

bind caseless_keyword_line_filter ckwlf_checker u_ckwlf_checker (
  .clk             (clk),
  .rst             (rst),
  .src_stall       (src_stall),
  .res_valid       (res_valid),
  .res_stall       (res_stall),
  .line_wanted     (line_wanted),
  .first_key_index (first_key_index)
);
